### hw/rtl/bkrt_pkg.sv
// shared types and constants for the keyed record table
package bkrt_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CMD_W           = 3;
  localparam int KEY_W           = 8;
  localparam int REC_W           = 64;
  localparam int TALLY_W         = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_READ   = 3'd2,
    CMD_EXISTS = 3'd3,
    CMD_COUNT  = 3'd4,
    CMD_FULL   = 3'd5,
    CMD_LIST   = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_LIST_RD,
    S_LIST_EMIT,
    S_DONE
  } state_t;

endpackage

### hw/rtl/bkrt_store.sv
// record memory: one write port, one registered read port
module bkrt_store import bkrt_pkg::*; #(
  parameter int DEPTH  = MAX_ENTRIES_DEF,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [REC_W-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [REC_W-1:0]  rdata
);

  logic [REC_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bounded_keyed_record_table.sv
// keyed record table top level: command sequencer, count, result register
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_ready   command, key, year, course/grade pairs
//  result    out        out_valid / out_ready ok, out_key, record bytes, tally, last
//
// one command at a time; in_ready is high only while the sequencer is idle
// add, count, full: result goes through S_DISPATCH and S_DONE to the output register
// delete, read, exists: one stored key compared per cycle, newest first;
//   delete then shifts each later record down one slot to close the gap
// list: newest first; each key goes S_LIST_RD, then S_LIST_EMIT, held by output stalls
// rst is synchronous: clears count and control, not the memory; a stalled result holds
//   the sequencer, but a result waiting after the sequencer is idle does not block input
module bounded_keyed_record_table import bkrt_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   command,
  input  logic [KEY_W-1:0]   key,
  input  logic [7:0]         year,
  input  logic [7:0]         course_one,
  input  logic [7:0]         grade_one,
  input  logic [7:0]         course_two,
  input  logic [7:0]         grade_two,
  input  logic [7:0]         course_three,
  input  logic [7:0]         grade_three,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ok,
  output logic [KEY_W-1:0]   out_key,
  output logic [7:0]         out_year,
  output logic [7:0]         out_course_one,
  output logic [7:0]         out_grade_one,
  output logic [7:0]         out_course_two,
  output logic [7:0]         out_grade_two,
  output logic [7:0]         out_course_three,
  output logic [7:0]         out_grade_three,
  output logic [TALLY_W-1:0] tally,
  output logic               last
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  // sequencer state
  state_t          state, state_next;
  cmd_t            cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [REC_W-1:0] rec_in;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   ptr, ptr_next;
  logic [CW-1:0]   pos, pos_next;
  logic            pend, pend_next;
  logic [AW-1:0]   pend_idx, pend_idx_next;

  // pending single result
  logic            res_ok, res_ok_next;
  logic [REC_W-1:0] res_rec, res_rec_next;
  logic [TALLY_W-1:0] res_tally, res_tally_next;

  // output register
  logic            out_valid_next;
  logic            load;
  logic            load_ok, load_last;
  logic [REC_W-1:0] load_rec;
  logic [TALLY_W-1:0] load_tally;
  logic [REC_W-1:0] out_rec;

  // memory port
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [REC_W-1:0] wdata, rd_data;

  logic            accept;
  logic            slot_free;
  logic            match;
  logic [CW-1:0]   ptr_dec;
  logic [CW+TALLY_W-1:0] count_ext, pos_ext;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign ptr_dec   = ptr - CW'(1);
  assign match     = pend && (rd_data[KEY_W-1:0] == key_r);
  // tally is the low bits of a count or position
  assign count_ext = {{TALLY_W{1'b0}}, count};
  assign pos_ext   = {{TALLY_W{1'b0}}, pos};

  bkrt_store #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= cmd_t'(command);
      key_r  <= key;
      rec_in <= {grade_three, course_three, grade_two, course_two,
                 grade_one, course_one, year, key};
    end
    ptr       <= ptr_next;
    pos       <= pos_next;
    pend_idx  <= pend_idx_next;
    res_ok    <= res_ok_next;
    res_rec   <= res_rec_next;
    res_tally <= res_tally_next;
    if (load) begin
      ok      <= load_ok;
      out_rec <= load_rec;
      tally   <= load_tally;
      last    <= load_last;
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    ptr_next       = ptr;
    pos_next       = pos;
    pend_next      = pend;
    pend_idx_next  = pend_idx;
    res_ok_next    = res_ok;
    res_rec_next   = res_rec;
    res_tally_next = res_tally;
    we             = 1'b0;
    waddr          = pend_idx - AW'(1);
    wdata          = rd_data;
    raddr          = ptr_dec[AW-1:0];
    load           = 1'b0;
    load_ok        = res_ok;
    load_rec       = res_rec;
    load_tally     = res_tally;
    load_last      = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_ok_next    = 1'b0;
          res_rec_next   = '0;
          res_tally_next = '0;
          state_next     = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_next = S_DONE;
        case (cmd_r)
          CMD_ADD: begin
            if (count < CW'(MAX_ENTRIES)) begin
              we          = 1'b1;
              waddr       = count[AW-1:0];
              wdata       = rec_in;
              count_next  = count + CW'(1);
              res_ok_next = 1'b1;
            end
          end
          CMD_DELETE, CMD_READ, CMD_EXISTS: begin
            ptr_next   = count;
            pend_next  = 1'b0;
            state_next = S_SCAN;
          end
          CMD_COUNT: begin
            res_ok_next    = 1'b1;
            res_tally_next = count_ext[TALLY_W-1:0];
          end
          CMD_FULL: begin
            res_ok_next = (count == CW'(MAX_ENTRIES));
          end
          CMD_LIST: begin
            if (count != '0) begin
              ptr_next   = count;
              pos_next   = CW'(1);
              state_next = S_LIST_RD;
            end
          end
          default: begin
          end
        endcase
      end

      // newest first: issue one read per cycle, compare the one issued last cycle
      S_SCAN: begin
        if (ptr != '0) begin
          pend_next     = 1'b1;
          pend_idx_next = ptr_dec[AW-1:0];
          ptr_next      = ptr_dec;
        end else begin
          pend_next = 1'b0;
        end
        if (match) begin
          res_ok_next = 1'b1;
          case (cmd_r)
            CMD_READ: begin
              res_rec_next = rd_data;
              state_next   = S_DONE;
            end
            CMD_DELETE: begin
              ptr_next   = CW'(pend_idx) + CW'(1);
              pend_next  = 1'b0;
              state_next = S_SHIFT;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end else if (ptr == '0) begin
          state_next = S_DONE;
        end
      end

      // close the gap: read entry i, write it to i - 1 in the next cycle
      S_SHIFT: begin
        raddr = ptr[AW-1:0];
        if (ptr < count) begin
          pend_next     = 1'b1;
          pend_idx_next = ptr[AW-1:0];
          ptr_next      = ptr + CW'(1);
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          we = 1'b1;
        end else if (ptr >= count) begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end

      S_LIST_RD: begin
        state_next = S_LIST_EMIT;
      end

      S_LIST_EMIT: begin
        if (slot_free) begin
          load       = 1'b1;
          load_ok    = 1'b1;
          load_rec   = {{(REC_W-KEY_W){1'b0}}, rd_data[KEY_W-1:0]};
          load_tally = pos_ext[TALLY_W-1:0];
          load_last  = (ptr == CW'(1));
          ptr_next   = ptr_dec;
          pos_next   = pos + CW'(1);
          state_next = (ptr == CW'(1)) ? S_IDLE : S_LIST_RD;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign out_key          = out_rec[7:0];
  assign out_year         = out_rec[15:8];
  assign out_course_one   = out_rec[23:16];
  assign out_grade_one    = out_rec[31:24];
  assign out_course_two   = out_rec[39:32];
  assign out_grade_two    = out_rec[47:40];
  assign out_course_three = out_rec[55:48];
  assign out_grade_three  = out_rec[63:56];

endmodule

### tb/sv/tb_bounded_keyed_record_table.sv
// self-checking testbench for the keyed record table: directed and random command streams
module tb_bounded_keyed_record_table;
  import bkrt_pkg::*;

  localparam int TBL_DEPTH   = MAX_ENTRIES_DEF;
  localparam int RAND_ITEMS  = 320;
  localparam int HOLD_AFTER  = 60;      // accepted transfers before the long receiver hold
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 80;      // covers a full list walk after the last result
  localparam int CYCLE_LIMIT = 600000;
  localparam int SHOW_MAX    = 10;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [7:0]       year;
    logic [7:0]       course_one;
    logic [7:0]       grade_one;
    logic [7:0]       course_two;
    logic [7:0]       grade_two;
    logic [7:0]       course_three;
    logic [7:0]       grade_three;
  } rec_t;

  typedef struct packed {
    logic               ok;
    rec_t               rec;
    logic [TALLY_W-1:0] tally;
    logic               last;
  } reply_t;

  typedef struct packed {
    logic             drain;    // hold this command back until every reply is in
    logic [CMD_W-1:0] op;
    rec_t             rec;
  } cmd_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   command = '0;
  logic [KEY_W-1:0]   key = '0;
  logic [7:0]         year = '0;
  logic [7:0]         course_one = '0;
  logic [7:0]         grade_one = '0;
  logic [7:0]         course_two = '0;
  logic [7:0]         grade_two = '0;
  logic [7:0]         course_three = '0;
  logic [7:0]         grade_three = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               ok;
  logic [KEY_W-1:0]   out_key;
  logic [7:0]         out_year;
  logic [7:0]         out_course_one;
  logic [7:0]         out_grade_one;
  logic [7:0]         out_course_two;
  logic [7:0]         out_grade_two;
  logic [7:0]         out_course_three;
  logic [7:0]         out_grade_three;
  logic [TALLY_W-1:0] tally;
  logic               last;

  bounded_keyed_record_table #(
    .MAX_ENTRIES(TBL_DEPTH)
  ) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .key(key), .year(year),
    .course_one(course_one), .grade_one(grade_one),
    .course_two(course_two), .grade_two(grade_two),
    .course_three(course_three), .grade_three(grade_three),
    .out_valid(out_valid), .out_ready(out_ready),
    .ok(ok), .out_key(out_key), .out_year(out_year),
    .out_course_one(out_course_one), .out_grade_one(out_grade_one),
    .out_course_two(out_course_two), .out_grade_two(out_grade_two),
    .out_course_three(out_course_three), .out_grade_three(out_grade_three),
    .tally(tally), .last(last)
  );

  always #5 clk = ~clk;

  // commands waiting to be driven, replies waiting to be seen
  cmd_item_t pend_q[$];
  reply_t    reply_q[$];

  // shadow of the record table, oldest record at index 0
  rec_t tbl [TBL_DEPTH];
  int   tbl_n = 0;

  int   total_items  = 0;
  int   accepted_cnt = 0;
  int   results_seen = 0;
  int   errors       = 0;
  int   cycle_cnt    = 0;

  // handshake flags, set at the rising edge and read at the falling edge
  logic in_fired  = 1'b0;
  logic out_fired = 1'b0;

  // ---------------------------------------------------------------------
  // table predictor: applies one command to the shadow and queues replies
  // ---------------------------------------------------------------------
  task automatic predict_replies(input logic [CMD_W-1:0] op, input rec_t r);
    reply_t rp;
    int     hit;
    int     i;
    hit = -1;
    // newest match is the highest index with that key
    for (i = 0; i < tbl_n; i++) begin
      if (tbl[i].key == r.key) hit = i;
    end
    rp = '0;
    rp.last = 1'b1;
    case (op)
      CMD_ADD: begin
        // a full table refuses the record
        if (tbl_n < TBL_DEPTH) begin
          tbl[tbl_n] = r;
          tbl_n++;
          rp.ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        // close the gap left by the removed record
        if (hit >= 0) begin
          for (i = hit; i + 1 < tbl_n; i++) tbl[i] = tbl[i + 1];
          tbl_n--;
          rp.ok = 1'b1;
        end
      end
      CMD_READ: begin
        if (hit >= 0) begin
          rp.ok  = 1'b1;
          rp.rec = tbl[hit];
        end
      end
      CMD_EXISTS: rp.ok = (hit >= 0);
      CMD_COUNT: begin
        rp.ok    = 1'b1;
        rp.tally = TALLY_W'(tbl_n);
      end
      CMD_FULL: rp.ok = (tbl_n >= TBL_DEPTH);
      CMD_LIST: begin
        // newest first with 1-based positions; an empty table gives one reply with ok low
        for (i = 0; i < tbl_n; i++) begin
          rp         = '0;
          rp.ok      = 1'b1;
          rp.rec.key = tbl[tbl_n - 1 - i].key;
          rp.tally   = TALLY_W'(i + 1);
          rp.last    = (i == tbl_n - 1);
          reply_q.push_back(rp);
        end
      end
      default: ;  // unknown command: state untouched, blank reply
    endcase
    if (!(op == CMD_LIST && tbl_n != 0)) reply_q.push_back(rp);
  endtask

  function automatic string fmt_reply(input reply_t r);
    return $sformatf("ok=%0d key=%02h yr=%02h c1=%02h g1=%02h c2=%02h g2=%02h c3=%02h g3=%02h tally=%0d last=%0d",
                     r.ok, r.rec.key, r.rec.year, r.rec.course_one, r.rec.grade_one,
                     r.rec.course_two, r.rec.grade_two, r.rec.course_three,
                     r.rec.grade_three, r.tally, r.last);
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= SHOW_MAX) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------
  // monitor: sees both transfers at the rising edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    cmd_item_t seen;
    cycle_cnt <= cycle_cnt + 1;
    in_fired  <= !rst && in_valid && in_ready;
    out_fired <= !rst && out_valid && out_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen.drain = 1'b0;
        seen.op    = command;
        seen.rec   = {key, year, course_one, grade_one, course_two, grade_two,
                      course_three, grade_three};
        predict_replies(seen.op, seen.rec);
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        got.ok  = ok;
        got.rec = {out_key, out_year, out_course_one, out_grade_one, out_course_two,
                   out_grade_two, out_course_three, out_grade_three};
        got.tally = tally;
        got.last  = last;
        results_seen++;
        if (reply_q.size() == 0) begin
          note_error($sformatf("unexpected reply: %s", fmt_reply(got)));
        end else begin
          want = reply_q.pop_front();
          if (got !== want) begin
            note_error($sformatf("reply mismatch at cycle %0d\n  want %s\n  got  %s",
                                 cycle_cnt, fmt_reply(want), fmt_reply(got)));
          end
        end
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_bounded_keyed_record_table: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // driver: presents queued commands at the falling edge
  // ---------------------------------------------------------------------
  int gap_left = 0;

  always @(negedge clk) begin
    int g;
    cmd_item_t cur;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_fired) begin
      // gap before the next command; some stretches run back to back
      if (in_fired) g = (accepted_cnt % 64 < 16) ? 0 : $urandom_range(0, 10);
      else          g = gap_left;
      if (g > 0) begin
        gap_left <= g - 1;
        in_valid <= 1'b0;
      end else if (pend_q.size() != 0 && (!pend_q[0].drain || reply_q.size() == 0)) begin
        cur          = pend_q.pop_front();
        gap_left     <= 0;
        in_valid     <= 1'b1;
        command      <= cur.op;
        key          <= cur.rec.key;
        year         <= cur.rec.year;
        course_one   <= cur.rec.course_one;
        grade_one    <= cur.rec.grade_one;
        course_two   <= cur.rec.course_two;
        grade_two    <= cur.rec.grade_two;
        course_three <= cur.rec.course_three;
        grade_three  <= cur.rec.grade_three;
      end else begin
        gap_left <= 0;
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: random stalls per reply, plus one long hold that backs up the block
  // ---------------------------------------------------------------------
  int   rx_wait   = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      rx_wait   <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (out_fired) w = (results_seen % 80 < 20) ? 0 : $urandom_range(0, 10);
      else           w = rx_wait;
      if (w > 0) begin
        rx_wait   <= w - 1;
        out_ready <= 1'b0;
      end else begin
        rx_wait   <= 0;
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  task automatic push_item(input logic drain, input logic [CMD_W-1:0] op, input rec_t r);
    cmd_item_t it;
    it.drain = drain;
    it.op    = op;
    it.rec   = r;
    pend_q.push_back(it);
    total_items++;
  endtask

  // small key pool so that duplicates, hits and misses all come up often
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      2, 3, 4: return KEY_W'($urandom_range(1, 4));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic rec_t rand_rec();
    rec_t r;
    r     = {$urandom, $urandom};
    r.key = pick_key();
    return r;
  endfunction

  function automatic rec_t keyed_rec(input logic [KEY_W-1:0] k);
    rec_t r;
    r     = {$urandom, $urandom};
    r.key = k;
    return r;
  endfunction

  initial begin
    int made;
    int n;
    int i;
    int pick;
    logic [CMD_W-1:0] op;

    // directed: empty-table corners, extremes, duplicates, deletes at both ends
    push_item(1'b0, CMD_COUNT,   rand_rec());
    push_item(1'b0, CMD_LIST,    rand_rec());
    push_item(1'b0, CMD_FULL,    rand_rec());
    push_item(1'b0, CMD_READ,    keyed_rec(8'h00));
    push_item(1'b0, CMD_DELETE,  keyed_rec(8'h00));
    push_item(1'b0, CMD_EXISTS,  keyed_rec(8'h00));
    push_item(1'b0, CMD_UNKNOWN, '1);
    push_item(1'b0, CMD_ADD,     '0);
    push_item(1'b0, CMD_ADD,     '1);
    push_item(1'b0, CMD_ADD,     keyed_rec(8'h5a));
    push_item(1'b0, CMD_ADD,     keyed_rec(8'hff));
    push_item(1'b0, CMD_READ,    keyed_rec(8'hff));
    push_item(1'b0, CMD_EXISTS,  keyed_rec(8'h00));
    push_item(1'b0, CMD_LIST,    rand_rec());
    push_item(1'b0, CMD_DELETE,  keyed_rec(8'hff));
    push_item(1'b0, CMD_READ,    keyed_rec(8'hff));
    push_item(1'b0, CMD_DELETE,  keyed_rec(8'h00));
    push_item(1'b0, CMD_COUNT,   rand_rec());
    push_item(1'b0, CMD_LIST,    rand_rec());
    push_item(1'b0, CMD_DELETE,  keyed_rec(8'hff));
    push_item(1'b0, CMD_DELETE,  keyed_rec(8'h5a));
    push_item(1'b0, CMD_DELETE,  keyed_rec(8'h5a));
    push_item(1'b0, CMD_COUNT,   rand_rec());

    // random: fill-and-drain runs that reach a full table, mixed with free command soup
    made = 0;
    while (made < RAND_ITEMS) begin
      if (made == 0 || $urandom_range(0, 3) == 0) begin
        // fill past capacity, probe the full table, then delete back down
        n = $urandom_range(TBL_DEPTH, TBL_DEPTH + 3);
        for (i = 0; i < n; i++) push_item(i == 0, CMD_ADD, rand_rec());
        push_item(1'b0, CMD_FULL,  rand_rec());
        push_item(1'b0, CMD_ADD,   rand_rec());
        push_item(1'b0, CMD_LIST,  rand_rec());
        push_item(1'b0, CMD_COUNT, rand_rec());
        for (i = 0; i < 3; i++) push_item(1'b0, CMD_READ, rand_rec());
        n = n + 7 + $urandom_range(TBL_DEPTH - 4, TBL_DEPTH + 4);
        for (i = n - $urandom_range(TBL_DEPTH - 4, TBL_DEPTH + 4); i < n; i++) begin
          push_item(1'b0, CMD_DELETE, rand_rec());
        end
        push_item(1'b0, CMD_COUNT, rand_rec());
        push_item(1'b0, CMD_LIST,  rand_rec());
        push_item(1'b0, CMD_FULL,  rand_rec());
        made = made + n + 3;
      end else begin
        n = $urandom_range(10, 25);
        for (i = 0; i < n; i++) begin
          pick = $urandom_range(0, 99);
          if      (pick < 35) op = CMD_ADD;
          else if (pick < 55) op = CMD_DELETE;
          else if (pick < 68) op = CMD_READ;
          else if (pick < 78) op = CMD_EXISTS;
          else if (pick < 84) op = CMD_COUNT;
          else if (pick < 89) op = CMD_FULL;
          else if (pick < 96) op = CMD_LIST;
          else                op = CMD_UNKNOWN;
          push_item(1'b0, op, rand_rec());
        end
        made = made + n;
      end
    end

    // reset, released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (accepted_cnt == total_items);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb_bounded_keyed_record_table: clean");
    end else begin
      $display("tb_bounded_keyed_record_table: errors");
    end
    $finish;
  end

endmodule
